// ===== src/receiver_mode_fault_controller_defines.svh =====
// assertion macros for the receiver mode fault controller
`ifndef RECEIVER_MODE_FAULT_CONTROLLER_DEFINES_SVH
`define RECEIVER_MODE_FAULT_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RMFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmfc same-cycle check failed");

// next-cycle implication, disabled during reset
`define RMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmfc next-cycle check failed");

`endif

// ===== src/rmfc_pkg.sv =====
// shared types and constants for the receiver mode fault controller
`default_nettype none

package rmfc_pkg;

    // frequency field width in kHz
    localparam int FREQ_W = 24;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [FREQ_W-1:0] AIR_MIN_RST  = FREQ_W'(118000);
    localparam logic [FREQ_W-1:0] AIR_MAX_RST  = FREQ_W'(137000);
    localparam logic [FREQ_W-1:0] LOCAL_OSC_RST = FREQ_W'(107300);
    localparam logic [FREQ_W-1:0] IF_MIN_RST   = FREQ_W'(10700);
    localparam logic [FREQ_W-1:0] IF_MAX_RST   = FREQ_W'(29700);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AIR_MIN   = 3'd0,
        CFG_AIR_MAX   = 3'd1,
        CFG_LOCAL_OSC = 3'd2,
        CFG_IF_MIN    = 3'd3,
        CFG_IF_MAX    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_OBSERVE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_DIRECT   = 2'd1,
        MODE_AIRBAND  = 2'd2,
        MODE_INVALID  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_DISABLED = 3'd0,
        ST_DIRECT   = 3'd1,
        ST_SETTLING = 3'd2,
        ST_ACTIVE   = 3'd3,
        ST_FAULT    = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_MODE  = 3'd1,
        FLT_RANGE = 3'd2,
        FLT_LINK  = 3'd3,
        FLT_LOST  = 3'd4
    } t_fault;

    // enable flags as kept in the controller
    typedef struct packed {
        logic rf_settled;
        logic osc_lock;
        logic air_mode_sel;
        logic air_rx;
        logic rx;
    } t_enables;

    // configuration registers as seen by the controller
    typedef struct packed {
        logic [FREQ_W-1:0] air_min;
        logic [FREQ_W-1:0] air_max;
        logic [FREQ_W-1:0] local_osc;
        logic [FREQ_W-1:0] if_min;
        logic [FREQ_W-1:0] if_max;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        mode;
        logic [FREQ_W-1:0] tune_khz;
        logic              link_up;
        logic              lo_locked_in;
        logic              rf_settled_in;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [2:0]        ctrl_state;
        logic [2:0]        first_fault_code;
        logic              receiver_enable;
        logic              air_path_en;
        logic              air_mode_select;
        logic              lo_locked_out;
        logic              rf_settled_out;
        logic [FREQ_W-1:0] tuned_khz;
        logic [FREQ_W-1:0] intermediate_khz;
    } t_out_item;

endpackage

`default_nettype wire

// ===== src/rmfc_cfg.sv =====
// configuration register file for the receiver mode fault controller
`default_nettype none

module rmfc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rmfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rmfc_pkg::FREQ_W-1:0]    i_cfg_data,
    output rmfc_pkg::t_cfg                     o_cfg
);
    import rmfc_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.air_min   <= AIR_MIN_RST;
            r_cfg.air_max   <= AIR_MAX_RST;
            r_cfg.local_osc <= LOCAL_OSC_RST;
            r_cfg.if_min    <= IF_MIN_RST;
            r_cfg.if_max    <= IF_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AIR_MIN:   r_cfg.air_min   <= i_cfg_data;
                CFG_AIR_MAX:   r_cfg.air_max   <= i_cfg_data;
                CFG_LOCAL_OSC: r_cfg.local_osc <= i_cfg_data;
                CFG_IF_MIN:    r_cfg.if_min    <= i_cfg_data;
                CFG_IF_MAX:    r_cfg.if_max    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/rmfc_ctrl.sv =====
// controller state registers and the per-item state update
`default_nettype none

module rmfc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire rmfc_pkg::t_in_item i_item,
    input  wire rmfc_pkg::t_cfg     i_cfg,
    output rmfc_pkg::t_out_item o_result
);
    import rmfc_pkg::*;

    t_state            r_state, n_state;
    t_fault            r_first, n_first;
    t_enables          r_en, n_en;
    logic [FREQ_W-1:0] r_tuned, n_tuned;
    logic [FREQ_W-1:0] r_ifreq, n_ifreq;
    logic              n_acc;
    logic [FREQ_W-1:0] if_diff;
    logic              tune_bad;
    logic              if_bad;

    // window checks and wrapped intermediate frequency
    assign if_diff  = i_item.tune_khz - i_cfg.local_osc;
    assign tune_bad = (i_item.tune_khz < i_cfg.air_min) ||
                      (i_item.tune_khz > i_cfg.air_max);
    assign if_bad   = (if_diff < i_cfg.if_min) || (if_diff > i_cfg.if_max);

    // next state for one item
    always_comb begin
        n_state = r_state;
        n_first = r_first;
        n_en    = r_en;
        n_tuned = r_tuned;
        n_ifreq = r_ifreq;
        n_acc   = 1'b0;
        unique case (t_action'(i_item.action))
            ACT_REQUEST: begin
                if (r_state != ST_FAULT) begin
                    unique case (t_mode'(i_item.mode))
                        MODE_DISABLED: begin
                            n_en    = '0;
                            n_tuned = '0;
                            n_ifreq = '0;
                            n_state = ST_DISABLED;
                            n_acc   = 1'b1;
                        end
                        MODE_DIRECT: begin
                            n_en    = '0;
                            n_en.rx = 1'b1;
                            n_tuned = i_item.tune_khz;
                            n_ifreq = '0;
                            n_state = ST_DIRECT;
                            n_acc   = 1'b1;
                        end
                        MODE_AIRBAND: begin
                            n_en    = '0;
                            n_tuned = i_item.tune_khz;
                            n_ifreq = '0;
                            if (tune_bad || if_bad) begin
                                // range fault, keeps the wrapped value if tuning passed
                                if (!tune_bad) begin
                                    n_ifreq = if_diff;
                                end
                                n_state = ST_FAULT;
                                n_first = (r_first == FLT_NONE) ? FLT_RANGE : r_first;
                            end else begin
                                n_ifreq          = if_diff;
                                n_state          = ST_SETTLING;
                                n_en.rx          = 1'b1;
                                n_en.air_rx      = 1'b1;
                                n_en.air_mode_sel = 1'b1;
                                n_acc            = 1'b1;
                            end
                        end
                        MODE_INVALID: begin
                            n_en    = '0;
                            n_state = ST_FAULT;
                            n_first = (r_first == FLT_NONE) ? FLT_MODE : r_first;
                        end
                    endcase
                end
            end
            ACT_OBSERVE: begin
                if (r_state != ST_FAULT) begin
                    if (!i_item.link_up) begin
                        n_en    = '0;
                        n_state = ST_FAULT;
                        n_first = (r_first == FLT_NONE) ? FLT_LINK : r_first;
                    end else if (r_state == ST_SETTLING) begin
                        n_en.osc_lock   = i_item.lo_locked_in;
                        n_en.rf_settled = i_item.rf_settled_in;
                        if (i_item.lo_locked_in && i_item.rf_settled_in) begin
                            n_state = ST_ACTIVE;
                        end
                    end else if (r_state == ST_ACTIVE &&
                                 !(i_item.lo_locked_in && i_item.rf_settled_in)) begin
                        n_en    = '0;
                        n_state = ST_FAULT;
                        n_first = (r_first == FLT_NONE) ? FLT_LOST : r_first;
                    end
                end
            end
            ACT_CLEAR: begin
                if (r_state == ST_FAULT && i_item.link_up) begin
                    n_state = ST_DISABLED;
                    n_first = FLT_NONE;
                    n_en    = '0;
                    n_tuned = '0;
                    n_ifreq = '0;
                    n_acc   = 1'b1;
                end
            end
            ACT_NONE: begin
            end
        endcase
    end

    // state registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DISABLED;
            r_first <= FLT_NONE;
            r_en    <= '0;
            r_tuned <= '0;
            r_ifreq <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_first <= n_first;
            r_en    <= n_en;
            r_tuned <= n_tuned;
            r_ifreq <= n_ifreq;
        end
    end

    // result shows the state after the item
    always_comb begin
        o_result.accepted         = n_acc;
        o_result.ctrl_state       = n_state;
        o_result.first_fault_code = n_first;
        o_result.receiver_enable  = n_en.rx;
        o_result.air_path_en      = n_en.air_rx;
        o_result.air_mode_select  = n_en.air_mode_sel;
        o_result.lo_locked_out    = n_en.osc_lock;
        o_result.rf_settled_out   = n_en.rf_settled;
        o_result.tuned_khz        = n_tuned;
        o_result.intermediate_khz = n_ifreq;
    end

endmodule

`default_nettype wire

// ===== src/receiver_mode_fault_controller.sv =====
// Receiver mode controller with a latching fault. Items are requests, status
// observations and fault clears; each item yields one result item with the
// state after it. The block takes one item per cycle while the output side is
// ready: an item is held in the input register while the state update runs on
// it, and the result register takes the outcome when the item moves on; the
// result register then offers it. The state registers are updated once per
// item, as it moves on. Configuration registers are written through a plain
// write port and are read directly by the state update.
`default_nettype none

module receiver_mode_fault_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire rmfc_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output rmfc_pkg::t_out_item                 o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [rmfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rmfc_pkg::FREQ_W-1:0]    i_cfg_data
);
    import rmfc_pkg::*;

    `include "receiver_mode_fault_controller_defines.svh"

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;
    logic       out_fault;
    logic       out_settling;
    logic       out_has_code;
    logic [4:0] out_en;

    // an item moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    rmfc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rmfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // result fields gathered for the checks below
    assign out_fault    = o_out_item.ctrl_state == ST_FAULT;
    assign out_settling = o_out_item.ctrl_state == ST_SETTLING;
    assign out_has_code = o_out_item.first_fault_code != FLT_NONE;
    assign out_en       = {o_out_item.rf_settled_out, o_out_item.lo_locked_out,
                           o_out_item.air_mode_select, o_out_item.air_path_en,
                           o_out_item.receiver_enable};

    // fault state forces every enable off
    `RMFC_ASSERT_NOW(a_fault_enables_off, i_clk, i_rst_n, o_out_valid && out_fault, out_en == 5'd0)
    // a fault code is held exactly while in fault
    `RMFC_ASSERT_NOW(a_fault_code_matches, i_clk, i_rst_n, o_out_valid, out_fault == out_has_code)
    // settling drives the airband path
    `RMFC_ASSERT_NOW(a_settling_enables, i_clk, i_rst_n, o_out_valid && out_settling, &out_en[2:0])
    // an item moving on always leaves a result behind
    `RMFC_ASSERT_NEXT(a_advance_fills_result, i_clk, i_rst_n, advance, r_out_valid)

endmodule

`default_nettype wire
